// ===== hdl/pdu_block_assembly_crc32_check_top_macros.svh =====
// Assertion macros used by the checker file of the PDU assembly block.
`ifndef PDU_BLOCK_ASSEMBLY_CRC32_CHECK_TOP_MACROS_SVH
`define PDU_BLOCK_ASSEMBLY_CRC32_CHECK_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PBAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbac check failed");

// Next-cycle implication, disabled while reset is low.
`define PBAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbac check failed");

`endif

// ===== hdl/pbac_pkg.sv =====
// Shared constants, types and item layouts of the PDU assembly and CRC32 check block.
`timescale 1ns / 1ps

package pbac_pkg;

    // Most data blocks taken into one unit is MAX_BLOCKS-1
    localparam int MAX_BLOCKS = 128;

    localparam int POS_W = 11;
    localparam int EB_W  = 7;

    localparam logic [EB_W-1:0] EB_MAX = EB_W'(MAX_BLOCKS - 1);

    // Byte positions within a unit
    localparam logic [POS_W-1:0] POS_B0        = POS_W'(0);
    localparam logic [POS_W-1:0] POS_B1        = POS_W'(1);
    localparam logic [POS_W-1:0] POS_BLKS      = POS_W'(6);
    localparam logic [POS_W-1:0] POS_HDR_LAST  = POS_W'(11);
    localparam logic [POS_W-1:0] POS_HDR_END   = POS_W'(12);
    localparam logic [POS_W-1:0] POS_CRC_START = POS_W'(16);
    localparam logic [POS_W-1:0] TOTAL_INIT    = POS_W'(36);
    localparam logic [POS_W-1:0] BLOCK_BYTES   = POS_W'(12);

    // CRC32 parameters
    localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;

    // Header codes
    localparam logic [5:0] SAP_TRUNK     = 6'h3D;
    localparam logic [4:0] FMT_CONFIRMED = 5'b10110;
    localparam logic [4:0] FMT_TRUNK_A   = 5'h17;
    localparam logic [4:0] FMT_TRUNK_B   = 5'h15;

    // One input item
    typedef struct packed {
        logic       header_crc_good;
        logic       first_byte;
        logic [7:0] data_byte;
    } pbac_item_t;

    // One result item
    typedef struct packed {
        logic        deliver;
        logic [31:0] crc_carried;
        logic [31:0] crc_computed;
        logic        crc_ok;
        logic        trunking_block;
        logic        confirmed_rate;
        logic        header_ok;
        logic [6:0]  block_count;
        logic [5:0]  service_point;
        logic [4:0]  format_code;
        logic        outbound;
        logic        ack_needed;
    } pbac_result_t;

endpackage

// ===== hdl/pdu_block_assembly_crc32_check_top.sv =====
// Top level of the PDU assembly and CRC32 check block.
// Takes one decoded byte per cycle (12 header bytes, then 12-byte data blocks) and
// returns one result item at the last byte of each unit. m_axis_tvalid rises after that
// byte passes the input register and then the result register; in the input register the
// header, position and eight-bit CRC32 update logic computes the result register's next
// value. A byte with first_byte set restarts the unit; bytes after a finished unit are
// dropped until the next restart. A result waiting on m_axis_tready holds the input only
// once the next byte would close a unit; bytes that produce no result keep flowing.
// strict_mode sits on the cfg channel, which is always ready; write it only between
// units. No clearing pass follows reset.
`timescale 1ns / 1ps

module pdu_block_assembly_crc32_check_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input byte items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [0] first_byte, [1] header_crc_good
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] ack_needed, [1] outbound, [6:2] format_code, [12:7] service_point,
    // [19:13] block_count, [20] header_ok, [21] confirmed_rate, [22] trunking_block,
    // [23] crc_ok, [55:24] crc_computed, [87:56] crc_carried, [88] deliver, [95:89] zero
    output logic [95:0] m_axis_tdata,
    // Mode register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data        // strict_mode
);
    import pbac_pkg::*;

    pbac_item_t   s_item, item;
    pbac_result_t result;
    logic         item_valid, advance;

    assign cfg_ready = 1'b1;

    // Unpack the input item
    assign s_item.data_byte       = s_axis_tdata;
    assign s_item.first_byte      = s_axis_tuser[0];
    assign s_item.header_crc_good = s_axis_tuser[1];

    pbac_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    pbac_assembler u_assembler (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_result   (result)
    );

    // Pack the result item, highest field first
    assign m_axis_tdata = {7'b0,
                           result.deliver,
                           result.crc_carried,
                           result.crc_computed,
                           result.crc_ok,
                           result.trunking_block,
                           result.confirmed_rate,
                           result.header_ok,
                           result.block_count,
                           result.service_point,
                           result.format_code,
                           result.outbound,
                           result.ack_needed};

endmodule

// ===== hdl/pbac_in_reg.sv =====
// Input register that holds one accepted byte item until the assembler takes it.
`timescale 1ns / 1ps

module pbac_in_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pbac_pkg::pbac_item_t s_item,
    input  logic               advance,
    output logic               item_valid,
    output pbac_pkg::pbac_item_t item
);
    import pbac_pkg::*;

    logic       valid_reg;
    pbac_item_t item_reg;

    // Take a new item when empty or when the held one moves on
    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== hdl/pbac_crc32_byte.sv =====
// Eight-bit unrolled CRC32 update, MSB first.
`timescale 1ns / 1ps

module pbac_crc32_byte (
    input  logic [31:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [31:0] crc_out
);
    import pbac_pkg::*;

    // Shift in one bit per step, most significant bit first
    always_comb begin
        logic [31:0] c;
        logic        fb;
        c = crc_in;
        for (int n = 7; n >= 0; n--) begin
            fb = c[31] ^ data_in[n];
            c  = {c[30:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        crc_out = c;
    end

endmodule

// ===== hdl/pbac_assembler.sv =====
// Unit assembly state, header parse, payload CRC and the result register.
`timescale 1ns / 1ps

module pbac_assembler (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic                   cfg_data,
    input  logic                   item_valid,
    input  pbac_pkg::pbac_item_t   item,
    output logic                   advance,
    output logic                   m_valid,
    input  logic                   m_ready,
    output pbac_pkg::pbac_result_t m_result
);
    import pbac_pkg::*;

    // Unit state
    logic             strict_reg;
    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [POS_W-1:0] total_reg, total_next;
    logic [6:0]       b0_reg,    b0_next;
    logic [7:0]       b1_reg,    b1_next;
    logic [6:0]       blk_reg,   blk_next;
    logic             hgood_reg, hgood_next;
    logic             acc_reg,   acc_next;
    logic [31:0]      crc_reg,   crc_next;
    logic [31:0]      tail_reg,  tail_next;

    // Result register
    logic         out_valid_reg;
    pbac_result_t out_reg, out_next;

    // Restart-adjusted view of the state
    logic [POS_W-1:0] pos_e, total_e;
    logic [6:0]       b0_e, blk_e;
    logic [7:0]       b1_e;
    logic             hgood_e, acc_e;
    logic [31:0]      crc_e, tail_e, crc_fed;

    logic             hdr_done, emit, fire;
    logic [EB_W-1:0]  eb;
    logic [EB_W:0]    eb_plus1;
    logic [31:0]      comp, carried;
    logic             ok, trunk, conf, dlv;

    // Bytes that close no unit pass even while a result waits
    assign advance  = !out_valid_reg || m_ready || !emit;
    assign fire     = item_valid && advance;
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    pbac_crc32_byte u_crc (
        .crc_in  (crc_e),
        .data_in (tail_e[31:24]),
        .crc_out (crc_fed)
    );

    // Restart on first byte, then advance the unit by one byte
    always_comb begin
        pos_e   = item.first_byte ? '0 : pos_reg;
        total_e = item.first_byte ? TOTAL_INIT : total_reg;
        b0_e    = item.first_byte ? '0 : b0_reg;
        b1_e    = item.first_byte ? '0 : b1_reg;
        blk_e   = item.first_byte ? '0 : blk_reg;
        hgood_e = item.first_byte ? 1'b0 : hgood_reg;
        acc_e   = item.first_byte ? 1'b0 : acc_reg;
        crc_e   = item.first_byte ? '0 : crc_reg;
        tail_e  = item.first_byte ? '0 : tail_reg;

        pos_next   = pos_e;
        total_next = total_e;
        b0_next    = b0_e;
        b1_next    = b1_e;
        blk_next   = blk_e;
        hgood_next = hgood_e;
        acc_next   = acc_e;
        crc_next   = crc_e;
        tail_next  = tail_e;
        hdr_done   = 1'b0;
        emit       = 1'b0;

        if (pos_e < total_e) begin
            pos_next = pos_e + POS_W'(1);
            if (pos_e < POS_HDR_END) begin
                // Capture header bytes 0, 1 and 6
                if (pos_e == POS_B0) begin
                    b0_next = item.data_byte[6:0];
                end
                if (pos_e == POS_B1) begin
                    b1_next = item.data_byte;
                end
                if (pos_e == POS_BLKS) begin
                    blk_next = item.data_byte[6:0];
                end
                // Last header byte: judge the header and size the unit
                if (pos_e == POS_HDR_LAST) begin
                    hdr_done   = 1'b1;
                    hgood_next = item.header_crc_good;
                    acc_next   = item.header_crc_good || !strict_reg;
                    if (!acc_next) begin
                        b0_next  = '0;
                        b1_next  = '0;
                        blk_next = '0;
                    end
                    crc_next  = '0;
                    tail_next = '0;
                end
            end else begin
                // Payload: the byte leaving the four-byte tail enters the CRC
                if (pos_e >= POS_CRC_START) begin
                    crc_next = crc_fed;
                end
                tail_next = {tail_e[23:0], item.data_byte};
                emit      = (pos_next == total_e);
            end
        end

        // Data blocks taken, capped
        if (!acc_next) begin
            eb = '0;
        end else if (blk_next > EB_MAX) begin
            eb = EB_MAX;
        end else begin
            eb = blk_next;
        end
        eb_plus1 = {1'b0, eb} + (EB_W + 1)'(1);

        if (hdr_done) begin
            total_next = POS_W'(eb_plus1) * BLOCK_BYTES;
            emit       = (eb == '0);
        end

        // Result fields from the updated state
        comp    = crc_next ^ CRC_XOROUT;
        carried = (eb != '0) ? tail_next : '0;
        ok      = (eb == '0) || (comp == carried);
        trunk   = (b1_next[5:0] == SAP_TRUNK) &&
                  ((b0_next[4:0] == FMT_TRUNK_A) || (b0_next[4:0] == FMT_TRUNK_B));
        conf    = b0_next[6] && (b0_next[4:0] == FMT_CONFIRMED);
        if (trunk) begin
            dlv = hgood_next && ok && b0_next[5] && (b0_next[4:0] == FMT_TRUNK_A) &&
                  (eb != '0);
        end else begin
            dlv = (eb != '0) && (ok || !strict_reg);
        end

        out_next.ack_needed     = b0_next[6];
        out_next.outbound       = b0_next[5];
        out_next.format_code    = b0_next[4:0];
        out_next.service_point  = b1_next[5:0];
        out_next.block_count    = blk_next;
        out_next.header_ok      = acc_next;
        out_next.confirmed_rate = conf;
        out_next.trunking_block = trunk;
        out_next.crc_ok         = ok;
        out_next.crc_computed   = comp;
        out_next.crc_carried    = carried;
        out_next.deliver        = dlv;
    end

    // Hold the mode bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_reg <= 1'b0;
        end else if (cfg_valid) begin
            strict_reg <= cfg_data;
        end
    end

    // Commit the unit state per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            total_reg <= TOTAL_INIT;
            b0_reg    <= '0;
            b1_reg    <= '0;
            blk_reg   <= '0;
            hgood_reg <= 1'b0;
            acc_reg   <= 1'b0;
            crc_reg   <= '0;
            tail_reg  <= '0;
        end else if (fire) begin
            pos_reg   <= pos_next;
            total_reg <= total_next;
            b0_reg    <= b0_next;
            b1_reg    <= b1_next;
            blk_reg   <= blk_next;
            hgood_reg <= hgood_next;
            acc_reg   <= acc_next;
            crc_reg   <= crc_next;
            tail_reg  <= tail_next;
        end
    end

    // Load a result or drop the one taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== hdl/pbac_checker.sv =====
// Port-level checks of the PDU assembly block, bound to its top level.
`timescale 1ns / 1ps
`include "pdu_block_assembly_crc32_check_top_macros.svh"

module pbac_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        cfg_data
);
    logic strict_reg;
    logic s_fire;
    logic out_stall;
    logic strict_dlv;
    logic res_deliver, res_trunk, res_ok;

    assign s_fire      = s_axis_tvalid && s_axis_tready;
    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign res_deliver = m_axis_tdata[88];
    assign res_trunk   = m_axis_tdata[22];
    assign res_ok      = m_axis_tdata[23];
    assign strict_dlv  = m_axis_tvalid && strict_reg && res_deliver && !res_trunk;

    // Track the mode bit as written on the cfg channel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            strict_reg <= cfg_data;
        end
    end

    // A stalled result holds
    `PBAC_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // A rising result valid must follow an accepted input item
    `PBAC_ASSERT_IMP(a_rise_after_accept, aclk, aresetn, $rose(m_axis_tvalid), $past(s_fire, 2))

    // Strict mode never delivers a non-trunking payload with a CRC mismatch
    `PBAC_ASSERT_IMP(a_strict_deliver, aclk, aresetn, strict_dlv, res_ok)

endmodule

bind pdu_block_assembly_crc32_check_top pbac_checker u_pbac_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
);
